// ===== sv/srit_pkg.sv =====
// ----------------------------------------------------------------------------
// srit_pkg - shared types, constants and a helper for the sorted record insert table
// Record layout, request codes and the name normalizer.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int unsigned NAME_W         = 64;
    localparam int unsigned GRADE_W        = 7;
    localparam int unsigned INDEX_W        = 7;
    localparam int unsigned COUNT_OUT_W    = 8;
    localparam int unsigned SRIT_CAPACITY  = 128;
    localparam int unsigned NAME_CHARS     = 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        logic [NAME_W-1:0]  last_name;
        logic [NAME_W-1:0]  first_name;
        logic [GRADE_W-1:0] grade;
    } t_rec;

    // Keep the top NAME_CHARS bytes up to the first NUL, clear the rest.
    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] res;
        logic              live;
        res  = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (live && (b < NAME_CHARS) && (v[NAME_W-1-8*b -: 8] != 8'h00)) begin
                res[NAME_W-1-8*b -: 8] = v[NAME_W-1-8*b -: 8];
            end else begin
                live = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/srit_mem.sv =====
// ----------------------------------------------------------------------------
// srit_mem - record store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srit_mem
    import srit_pkg::*;
#(
    parameter int unsigned DEPTH = SRIT_CAPACITY,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sorted_record_insert_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_record_insert_table_core - table of records kept sorted by name
// Insertion into a sorted list through one record store and one key compare.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: an insert
//   (last name, first name, grade) or a read of the record at i_index.
//   Output channel (o_out_valid / i_out_stall) returns one result per request
//   with the record read (reads only), the entry count and a dropped flag.
//   An insert walks the table from its end, one entry per cycle, moving
//   larger keys up by one; equal keys keep arrival order. An insert passes
//   through S_FETCH and S_WALK (S_WALK alone on an empty table), a read
//   through S_FETCH and S_READ; a dropped insert or an out-of-range read
//   goes straight to S_EMIT. The result is loaded once the output is free.
//   One request is worked at a time: o_in_stall is high from acceptance
//   until the result is loaded; the next request is taken back in S_IDLE.
//   A full table refuses an insert and reports dropped. The result register
//   holds while the receiver stalls; a finished request waits for it.
//   Reset empties the table at once; the store is not cleared, since only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_record_insert_table_core
    import srit_pkg::*;
#(
    parameter int unsigned CAPACITY = SRIT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_op,
    input  logic [NAME_W-1:0]      i_last_name,
    input  logic [NAME_W-1:0]      i_first_name,
    input  logic [GRADE_W-1:0]     i_grade,
    input  logic [INDEX_W-1:0]     i_index,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [NAME_W-1:0]      o_last_name_out,
    output logic [NAME_W-1:0]      o_first_name_out,
    output logic [GRADE_W-1:0]     o_grade_out,
    output logic                   o_entry_valid,
    output logic [COUNT_OUT_W-1:0] o_entry_count,
    output logic                   o_dropped
);

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_READ,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_pos, n_pos;
    t_op                 r_op, n_op;
    logic                r_drop, n_drop;
    t_rec                r_new, n_new;

    logic                r_out_valid, n_out_valid;
    t_rec                r_out_rec, n_out_rec;
    logic                r_out_entry_valid, n_out_entry_valid;
    logic [CW-1:0]       r_out_count, n_out_count;
    logic                r_out_drop, n_out_drop;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    t_rec                mem_wdata;
    t_rec                mem_rdata;

    logic                out_free;
    logic                key_before;
    logic                load;
    logic                ld_valid;

    srit_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign key_before = {r_new.last_name, r_new.first_name}
                      < {mem_rdata.last_name, mem_rdata.first_name};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_op      = r_op;
        n_drop    = r_drop;
        n_new     = r_new;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_pos);
        mem_wdata = r_new;
        mem_raddr = AW'(r_pos - CW'(1));
        load      = 1'b0;
        ld_valid  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op             = t_op'(i_op);
                    n_drop           = 1'b0;
                    n_new.last_name  = norm_name(i_last_name);
                    n_new.first_name = norm_name(i_first_name);
                    n_new.grade      = i_grade;
                    if (t_op'(i_op) == OP_INSERT) begin
                        n_pos = r_count;
                        if (r_count == CW'(CAPACITY)) begin
                            n_drop  = 1'b1;
                            n_state = S_EMIT;
                        end else if (r_count == '0) begin
                            n_state = S_WALK;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end else if (CMP_W'(i_index) < CMP_W'(r_count)) begin
                        n_pos   = CW'(i_index);
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FETCH: begin
                if (r_op == OP_READ) begin
                    mem_raddr = AW'(r_pos);
                    n_state   = S_READ;
                end else begin
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if ((r_pos != '0) && key_before) begin
                    // move the larger entry up and look one place lower
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    mem_raddr = AW'(r_pos - CW'(2));
                    n_pos     = r_pos - CW'(1);
                end else if (out_free) begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                mem_raddr = AW'(r_pos);
                if (out_free) begin
                    load     = 1'b1;
                    ld_valid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid       = r_out_valid && i_out_stall;
        n_out_rec         = r_out_rec;
        n_out_entry_valid = r_out_entry_valid;
        n_out_count       = r_out_count;
        n_out_drop        = r_out_drop;
        if (load) begin
            n_out_valid       = 1'b1;
            n_out_rec         = ld_valid ? mem_rdata : '0;
            n_out_entry_valid = ld_valid;
            n_out_count       = n_count;
            n_out_drop        = r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos             <= n_pos;
        r_op              <= n_op;
        r_drop            <= n_drop;
        r_new             <= n_new;
        r_out_rec         <= n_out_rec;
        r_out_entry_valid <= n_out_entry_valid;
        r_out_count       <= n_out_count;
        r_out_drop        <= n_out_drop;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_last_name_out  = r_out_rec.last_name;
    assign o_first_name_out = r_out_rec.first_name;
    assign o_grade_out      = r_out_rec.grade;
    assign o_entry_valid    = r_out_entry_valid;
    assign o_entry_count    = COUNT_OUT_W'(r_out_count);
    assign o_dropped        = r_out_drop;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (r_out_count == CW'(CAPACITY)))
        else $error("drop reported on a table that is not full");

    a_read_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_valid) |-> !o_dropped)
        else $error("read result flagged as dropped");

    a_write_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_WALK && r_op == OP_INSERT))
        else $error("store written outside an insert walk");
`endif

endmodule
